// ----- rtl/rsd_pkg.sv -----
package rsd_pkg;

   // default geometry of the readout
   localparam int DIGITS_PER_LINE_DEF = 6;
   localparam int LINE_COUNT_DEF      = 3;

   // widest line the command word can carry
   localparam int MAX_DIGITS = 8;
   localparam int COUNT_W    = 4;
   localparam int AXIS_W     = 2;
   localparam int SCAN_W     = 5;
   localparam int FLIP_W     = 3;

   // command queue between parser and display side
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // segment patterns
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_POINT = 8'h80;
   localparam logic [7:0] SEG_ERROR = 8'h79;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   // character codes
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_COLON  = 8'h3a;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_AXIS_X = 8'h58;

   // digit that carries the decimal point
   localparam int POINT_DIGIT = 3;

   // glyphs for '0'..'9' and ':' (blank), entry 0 in the lowest byte
   localparam logic [10:0][7:0] GLYPHS = {
      8'h00, 8'h67, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };

   typedef logic [MAX_DIGITS-1:0][7:0] line_type;

   // one queued command: a scan tick or a line rebuild
   typedef struct packed {
      logic               tick;
      logic               minus;
      logic [AXIS_W-1:0]  axis;
      logic [COUNT_W-1:0] count;
      line_type           line;
   } cmd_type;

   // character to segment pattern
   function automatic logic [7:0] glyph_of(input logic [7:0] code);
      logic [7:0] ofs;
      ofs = code - CHAR_ZERO;
      if (code >= CHAR_ZERO && code <= CHAR_COLON) begin
         return GLYPHS[ofs[3:0]];
      end
      return SEG_ERROR;
   endfunction

endpackage

// ----- rtl/readout_seven_segment_display.sv -----
// Multiplexed seven-segment readout for LINE_COUNT axis lines of
// DIGITS_PER_LINE digits.
// req channel: one word per character or scan tick. tuser is the kind
// (0 character, 1 tick), tdata the character byte, tlast ends a message.
// A message is an axis letter X/Y/Z, optional colons, an optional minus and
// the characters; on tlast the axis line is rebuilt in the display store.
// rsp channel: one word per tick, tdata holds segments in bits 7:0 and the
// common index (axis * DIGITS_PER_LINE + position) in bits 12:8.
// csr channel: writes sign_flip (bit a inverts the sign of axis a); always
// ready, to be written only while the block is idle.
// Throughput: one req word per cycle while the command queue is not full.
// A tick's word enters the command queue, and from there the display stage
// reads the store into the output register.
// When rsp stalls the output word holds; ticks wait in the two-entry queue
// and req_tready drops once it is full.
// Reset clears the parser and scan position and fills every digit with a
// minus; sign_flip resets to zero.
module readout_seven_segment_display #(
   parameter int DIGITS_PER_LINE = rsd_pkg::DIGITS_PER_LINE_DEF,
   parameter int LINE_COUNT      = rsd_pkg::LINE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // char_code
   input  logic        req_tuser,    // kind
   input  logic        req_tlast,    // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // segments [7:0], common_index [12:8], zero [15:13]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data      // sign_flip
);

   logic                        accept;
   logic                        push, full, pop, empty;
   rsd_pkg::cmd_type            push_data, pop_data;
   logic [rsd_pkg::FLIP_W-1:0]  sign_flip_ff;
   logic [7:0]                  segments;
   logic [rsd_pkg::SCAN_W-1:0]  common_index;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         sign_flip_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         sign_flip_ff <= csr_data;
      end
   end

   rsd_front #(
      .DIGITS_PER_LINE(DIGITS_PER_LINE),
      .LINE_COUNT     (LINE_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .kind     (req_tuser),
      .char_code(req_tdata),
      .last     (req_tlast),
      .push     (push),
      .push_data(push_data)
   );

   rsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (empty)
   );

   rsd_back #(
      .DIGITS_PER_LINE(DIGITS_PER_LINE),
      .LINE_COUNT     (LINE_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!empty),
      .cmd         (pop_data),
      .cmd_pop     (pop),
      .sign_flip   (sign_flip_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_segments(segments),
      .out_index   (common_index)
   );

   assign rsp_tdata = {3'b000, common_index, segments};

endmodule

// ----- rtl/rsd_front.sv -----
module rsd_front #(
   parameter int DIGITS_PER_LINE = rsd_pkg::DIGITS_PER_LINE_DEF,
   parameter int LINE_COUNT      = rsd_pkg::LINE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             kind,
   input  logic [7:0]       char_code,
   input  logic             last,
   output logic             push,
   output rsd_pkg::cmd_type push_data
);

   typedef enum logic [3:0] {
      PH_AXIS   = 4'b0001,
      PH_PREFIX = 4'b0010,
      PH_CHARS  = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   phase_type                   phase_ff, phase_in, phase_mid;
   logic [rsd_pkg::AXIS_W-1:0]  axis_ff, axis_in;
   logic                        minus_ff, minus_in;
   logic [rsd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0]                  stage_ff [DIGITS_PER_LINE];
   logic [7:0]                  stage_in [DIGITS_PER_LINE];
   logic                        do_push_char;
   logic                        axis_ok;
   logic                        rebuild;
   logic [7:0]                  axis_ofs;

   assign axis_ofs = char_code - rsd_pkg::CHAR_AXIS_X;
   assign axis_ok  = ({1'b0, char_code} >= {1'b0, rsd_pkg::CHAR_AXIS_X}) &&
                     ({1'b0, char_code} < 9'({1'b0, rsd_pkg::CHAR_AXIS_X} + 9'(LINE_COUNT)));

   // parser next state
   always_comb begin
      phase_mid    = phase_ff;
      axis_in      = axis_ff;
      minus_in     = minus_ff;
      count_in     = count_ff;
      do_push_char = 1'b0;
      for (int i = 0; i < DIGITS_PER_LINE; i++) begin
         stage_in[i] = stage_ff[i];
      end
      case (phase_ff)
         PH_AXIS: begin
            if (axis_ok) begin
               axis_in   = axis_ofs[rsd_pkg::AXIS_W-1:0];
               minus_in  = 1'b0;
               count_in  = '0;
               phase_mid = PH_PREFIX;
               for (int i = 0; i < DIGITS_PER_LINE; i++) begin
                  stage_in[i] = rsd_pkg::SEG_BLANK;
               end
            end else begin
               phase_mid = PH_SKIP;
            end
         end
         PH_PREFIX: begin
            if (char_code != rsd_pkg::CHAR_COLON) begin
               phase_mid = PH_CHARS;
               if (char_code == rsd_pkg::CHAR_MINUS) begin
                  minus_in = 1'b1;
               end else begin
                  do_push_char = 1'b1;
               end
            end
         end
         PH_CHARS: begin
            do_push_char = 1'b1;
         end
         default: begin
         end
      endcase
      // shift the new glyph in from the right
      if (do_push_char) begin
         for (int i = 0; i < DIGITS_PER_LINE - 1; i++) begin
            stage_in[i] = stage_ff[i + 1];
         end
         stage_in[DIGITS_PER_LINE-1] = rsd_pkg::glyph_of(char_code);
         if (count_ff < rsd_pkg::COUNT_W'(DIGITS_PER_LINE)) begin
            count_in = count_ff + 1'b1;
         end
      end
      rebuild  = last && (phase_mid == PH_PREFIX || phase_mid == PH_CHARS);
      phase_in = last ? PH_AXIS : phase_mid;
   end

   // command word for the display side
   always_comb begin
      push_data       = '0;
      push_data.tick  = kind;
      push_data.minus = minus_in;
      push_data.axis  = axis_in;
      push_data.count = count_in;
      for (int i = 0; i < DIGITS_PER_LINE; i++) begin
         push_data.line[i] = stage_in[i];
      end
   end

   assign push = accept && (kind || rebuild);

   // parser registers, ticks leave them untouched
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_AXIS;
         axis_ff  <= '0;
         minus_ff <= 1'b0;
         count_ff <= '0;
         for (int i = 0; i < DIGITS_PER_LINE; i++) begin
            stage_ff[i] <= rsd_pkg::SEG_BLANK;
         end
      end else if (accept && !kind) begin
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
         minus_ff <= minus_in;
         count_ff <= count_in;
         for (int i = 0; i < DIGITS_PER_LINE; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

endmodule

// ----- rtl/rsd_queue.sv -----
module rsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output rsd_pkg::cmd_type pop_data,
   output logic             empty
);

   rsd_pkg::cmd_type           mem_ff [rsd_pkg::QUEUE_DEPTH];
   logic [rsd_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rsd_pkg::QPTR_W:0]   count_ff;
   logic                       do_push, do_pop;

   assign full     = count_ff == (rsd_pkg::QPTR_W+1)'(rsd_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/rsd_back.sv -----
module rsd_back #(
   parameter int DIGITS_PER_LINE = rsd_pkg::DIGITS_PER_LINE_DEF,
   parameter int LINE_COUNT      = rsd_pkg::LINE_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  rsd_pkg::cmd_type           cmd,
   output logic                       cmd_pop,
   input  logic [rsd_pkg::FLIP_W-1:0] sign_flip,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [7:0]                 out_segments,
   output logic [rsd_pkg::SCAN_W-1:0] out_index
);

   localparam int TOTAL_DIGITS = DIGITS_PER_LINE * LINE_COUNT;
   localparam int IDX_W        = (TOTAL_DIGITS > 1) ? $clog2(TOTAL_DIGITS) : 1;

   logic [7:0]       store_ff [TOTAL_DIGITS];
   logic [IDX_W-1:0] scan_ff;
   logic             valid_ff;
   logic [7:0]       seg_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       new_line [DIGITS_PER_LINE];
   logic [3:0]       flip_ext;
   logic             negative;
   logic             tick_go, rebuild_go;

   assign tick_go    = cmd_valid && cmd.tick && (!valid_ff || out_ready);
   assign rebuild_go = cmd_valid && !cmd.tick;
   assign cmd_pop    = tick_go || rebuild_go;

   // sign after the per-axis flip, axis three has no flip bit
   assign flip_ext = {1'b0, sign_flip};
   assign negative = cmd.minus != flip_ext[cmd.axis];

   // rebuilt line: digits right-aligned, point, then sign left of the digits
   always_comb begin
      for (int i = 0; i < DIGITS_PER_LINE; i++) begin
         new_line[i] = rsd_pkg::SEG_BLANK;
         if ((5'(i) + 5'(cmd.count)) >= 5'(DIGITS_PER_LINE)) begin
            new_line[i] = cmd.line[i];
         end
         if (i == rsd_pkg::POINT_DIGIT) begin
            new_line[i] = new_line[i] | rsd_pkg::SEG_POINT;
         end
         if ((5'(i) + 5'(cmd.count)) == 5'(DIGITS_PER_LINE - 1)) begin
            new_line[i] = negative ? rsd_pkg::SEG_MINUS : rsd_pkg::SEG_BLANK;
         end
      end
   end

   // display store
   always_ff @(posedge clock) begin
      for (int e = 0; e < TOTAL_DIGITS; e++) begin
         if (reset) begin
            store_ff[e] <= rsd_pkg::SEG_MINUS;
         end else if (rebuild_go && cmd.axis == rsd_pkg::AXIS_W'(e / DIGITS_PER_LINE)) begin
            store_ff[e] <= new_line[e % DIGITS_PER_LINE];
         end
      end
   end

   // scan position
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (tick_go) begin
         if (scan_ff == IDX_W'(TOTAL_DIGITS - 1)) begin
            scan_ff <= '0;
         end else begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (tick_go) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_go) begin
         seg_ff <= store_ff[scan_ff];
         idx_ff <= scan_ff;
      end
   end

   assign out_valid    = valid_ff;
   assign out_segments = seg_ff;
   assign out_index    = rsd_pkg::SCAN_W'(idx_ff);

endmodule

// ----- rtl/rsd_checker.sv -----
module rsd_checker #(
   parameter int DIGITS_PER_LINE = rsd_pkg::DIGITS_PER_LINE_DEF,
   parameter int LINE_COUNT      = rsd_pkg::LINE_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   localparam int TOTAL_DIGITS = DIGITS_PER_LINE * LINE_COUNT;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // common index stays inside the digit array
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata[12:8]} < 6'(TOTAL_DIGITS))
      else $error("common index out of range");

   // reset leaves no result word pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a scan word is taken in order: the next index follows the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready ##1 rsp_tvalid && $past(rsp_tdata[12:8]) != 5'(TOTAL_DIGITS - 1)
      |-> rsp_tdata[12:8] == $past(rsp_tdata[12:8]) + 5'd1)
      else $error("scan index skipped");

   // register port never back-pressures
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind readout_seven_segment_display rsd_checker #(
   .DIGITS_PER_LINE(DIGITS_PER_LINE),
   .LINE_COUNT     (LINE_COUNT)
) u_rsd_checker (.*);

// ----- sim/segment_readout_checker.sv -----
package readout_tb_pkg;

   // kind carried on req_tuser
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // one display word as it should leave the rsp channel
   typedef struct packed {
      logic [7:0] segs;
      logic [4:0] digit;
   } digit_word_t;

endpackage

module segment_readout_checker
   import rsd_pkg::*;
   import readout_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // char_code
   input  logic        req_tuser,    // kind
   input  logic        req_tlast,    // last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // segments [7:0], common_index [12:8], zero [15:13]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_data,     // sign_flip
   output int          error_count,
   output int          digits_due,
   output int          digits_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIGITS = DIGITS_PER_LINE_DEF;
   localparam int LINES  = LINE_COUNT_DEF;
   localparam int TOTAL  = DIGITS * LINES;

   // patterns for '0'..'9', then ':' which shows blank
   localparam logic [7:0] DIGIT_SEGS [0:10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h67, 8'h00
   };

   typedef enum logic [1:0] {
      AWAIT_AXIS,
      AWAIT_PREFIX,
      IN_CHARS,
      SKIPPING
   } parse_state_t;

   // mirror of the display store and the message parser
   logic [7:0]   shown [TOTAL];
   logic [7:0]   recent [DIGITS];
   parse_state_t state;
   int           line_sel;
   bit           line_ok;
   bit           sign_neg;
   int           kept;
   int           scan_at;
   logic [2:0]   flip_bits;
   digit_word_t  due_digits [$];

   function automatic logic [7:0] char_segments(input logic [7:0] code);
      if (code >= CHAR_ZERO && code <= CHAR_COLON) begin
         return DIGIT_SEGS[code - CHAR_ZERO];
      end
      return SEG_ERROR;
   endfunction

   task automatic clear_model();
      foreach (shown[i]) shown[i] = SEG_MINUS;
      foreach (recent[i]) recent[i] = 8'h00;
      state     = AWAIT_AXIS;
      line_sel  = 0;
      line_ok   = 1'b0;
      sign_neg  = 1'b0;
      kept      = 0;
      scan_at   = 0;
      flip_bits = '0;
      due_digits.delete();
   endtask

   // shift a character in from the right, only the newest DIGITS survive
   task automatic keep_char(input logic [7:0] code);
      for (int i = 0; i < DIGITS - 1; i++) recent[i] = recent[i + 1];
      recent[DIGITS - 1] = char_segments(code);
      if (kept < DIGITS) kept++;
   endtask

   // clear the axis line, right-align, point into digit 3, sign written last
   task automatic redraw_line();
      int  base;
      bit  flip;
      bit  negative;
      base     = line_sel * DIGITS;
      flip     = (line_sel < FLIP_W) ? flip_bits[line_sel] : 1'b0;
      negative = sign_neg ^ flip;
      for (int i = 0; i < DIGITS; i++) begin
         shown[base + i] = (i >= DIGITS - kept) ? recent[i] : SEG_BLANK;
      end
      shown[base + POINT_DIGIT] = shown[base + POINT_DIGIT] | SEG_POINT;
      if (kept < DIGITS) begin
         shown[base + DIGITS - 1 - kept] = negative ? SEG_MINUS : SEG_BLANK;
      end
   endtask

   // one accepted req word
   task automatic take_word(input logic kind, input logic [7:0] code, input logic fin);
      digit_word_t nxt;
      if (kind == KIND_TICK) begin
         nxt.segs  = shown[scan_at];
         nxt.digit = 5'(scan_at);
         due_digits.push_back(nxt);
         scan_at = (scan_at + 1) % TOTAL;
         return;
      end
      case (state)
         AWAIT_AXIS: begin
            if (code >= CHAR_AXIS_X && code < CHAR_AXIS_X + LINES) begin
               line_sel = code - CHAR_AXIS_X;
               line_ok  = 1'b1;
               sign_neg = 1'b0;
               kept     = 0;
               foreach (recent[i]) recent[i] = 8'h00;
               state    = AWAIT_PREFIX;
            end else begin
               line_ok = 1'b0;
               state   = SKIPPING;
            end
         end
         AWAIT_PREFIX: begin
            if (code != CHAR_COLON) begin
               state = IN_CHARS;
               if (code == CHAR_MINUS) sign_neg = 1'b1;
               else keep_char(code);
            end
         end
         IN_CHARS: keep_char(code);
         default: ;
      endcase
      if (fin) begin
         if (line_ok && (state == AWAIT_PREFIX || state == IN_CHARS)) redraw_line();
         line_ok = 1'b0;
         state   = AWAIT_AXIS;
      end
   endtask

   // track config and input words, compare every output word
   always @(posedge clock) begin
      digit_word_t want;
      bit          bad;
      if (reset) begin
         clear_model();
         error_count    = 0;
         digits_checked = 0;
      end else begin
         if (csr_valid && csr_ready) flip_bits = csr_data;
         if (req_tvalid && req_tready) take_word(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (due_digits.size() == 0) begin
               $display("%0t: unexpected display word, expected none, got %h", $realtime,
                        rsp_tdata);
               error_count++;
            end else begin
               want = due_digits.pop_front();
               bad  = 1'b0;
               if (rsp_tdata[7:0] != want.segs) begin
                  $display("%0t: segments expected %h, got %h", $realtime, want.segs,
                           rsp_tdata[7:0]);
                  bad = 1'b1;
               end
               if (rsp_tdata[12:8] != want.digit) begin
                  $display("%0t: common index expected %0d, got %0d", $realtime, want.digit,
                           rsp_tdata[12:8]);
                  bad = 1'b1;
               end
               if (rsp_tdata[15:13] != 3'b000) begin
                  $display("%0t: padding expected 0, got %h", $realtime, rsp_tdata[15:13]);
                  bad = 1'b1;
               end
               if (bad) error_count++;
               digits_checked++;
            end
         end
      end
      digits_due = due_digits.size();
   end

endmodule

// ----- sim/tb.sv -----
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import rsd_pkg::*;
   import readout_tb_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_WORDS   = 125;
   localparam int TICK_PCT      = 30;
   localparam int TIMEOUT_NS    = 4_000_000;

   // sign_flip settings, one per phase, extremes first
   localparam logic [2:0] FLIP_PLAN [8] = '{
      3'b000, 3'b111, 3'b101, 3'b010, 3'b001, 3'b110, 3'b100, 3'b011
   };

   typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;
   typedef logic [7:0] byte_q_t [$];

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data   = 3'b000;

   int errors;
   int digits_due;
   int digits_checked;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_ask      = 1'b0;
   int words_sent    = 0;

   readout_seven_segment_display dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   segment_readout_checker readout_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .error_count    (errors),
      .digits_due     (digits_due),
      .digits_checked (digits_checked)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("[readout_seven_segment_display] ERROR");
      $finish;
   end

   // result side: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_ask = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic set_flow(input flow_t f);
      send_idle_pct = (f == FLOW_SEND_IDLE) ? 59 : (f == FLOW_BOTH) ? 15 : 0;
      stall_pct     = (f == FLOW_RECV_STALL) ? 59 : (f == FLOW_BOTH) ? 15 : 0;
   endtask

   // offer one word, with random idle cycles ahead of it
   task automatic put_word(input logic kind, input logic [7:0] code, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= code;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_tick();
      put_word(KIND_TICK, 8'($urandom), 1'($urandom));
   endtask

   // one message, ticks sprinkled between its characters
   task automatic send_chars(input byte_q_t bytes, input int tick_pct);
      foreach (bytes[i]) begin
         while ($urandom_range(99) < tick_pct) send_tick();
         put_word(KIND_CHAR, bytes[i], i == bytes.size() - 1);
      end
   endtask

   // stop offering and let every expected word come out
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (digits_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_flip(input logic [2:0] flip);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= flip;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return CHAR_ZERO + 8'($urandom_range(9));
      if (roll < 75) return CHAR_COLON;
      if (roll < 82) return CHAR_MINUS;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] random_axis();
      int roll;
      roll = $urandom_range(99);
      if (roll < 85) return CHAR_AXIS_X + 8'($urandom_range(2));
      if (roll < 90) return CHAR_AXIS_X - 8'd1;
      if (roll < 95) return CHAR_AXIS_X + 8'd3;
      return 8'($urandom);
   endfunction

   // mostly well-formed messages, some bare ticks and stray words
   task automatic random_traffic();
      byte_q_t bytes;
      int      roll;
      int      nchars;
      roll = $urandom_range(99);
      if (roll < 8) begin
         put_word(KIND_CHAR, 8'($urandom), 1'($urandom));
      end else if (roll < 20) begin
         send_tick();
      end else begin
         bytes.push_back(random_axis());
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) bytes.push_back(CHAR_COLON);
         if ($urandom_range(1) == 1) bytes.push_back(CHAR_MINUS);
         nchars = ($urandom_range(9) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 6);
         repeat (nchars) bytes.push_back(random_char());
         send_chars(bytes, TICK_PCT);
      end
   endtask

   // stimulus and verdict
   initial begin
      int phase_start;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_flip(FLIP_PLAN[0]);

      // directed: reset contents, ticks carrying junk and last
      put_word(KIND_TICK, 8'hff, 1'b1);
      put_word(KIND_TICK, 8'h00, 1'b0);
      // axis letter alone
      send_chars('{CHAR_AXIS_X}, 0);
      // leading colons, sign, nine and a blank
      send_chars('{CHAR_AXIS_X + 8'd1, CHAR_COLON, CHAR_COLON, CHAR_MINUS, CHAR_ZERO + 8'd9,
                   CHAR_COLON}, 0);
      // too long, sign has no room
      send_chars('{CHAR_AXIS_X + 8'd2, CHAR_ZERO, CHAR_ZERO + 8'd1, CHAR_ZERO + 8'd2,
                   CHAR_ZERO + 8'd3, CHAR_ZERO + 8'd4, CHAR_ZERO + 8'd5, CHAR_ZERO + 8'd6}, 0);
      // bad axis letter
      send_chars('{8'hff, CHAR_ZERO + 8'd5}, 0);
      // second minus and odd bytes show as E
      send_chars('{CHAR_AXIS_X, CHAR_MINUS, CHAR_MINUS, 8'h00, 8'hff}, 0);

      // hold the result side while ticks keep coming, then drain fully
      hold_ask = 1'b1;
      repeat (16) send_tick();
      wait_quiet();

      // random phases across flow mixes and sign_flip settings
      for (int p = 0; p < 8; p++) begin
         if (p != 0) begin
            wait_quiet();
            write_flip(FLIP_PLAN[p]);
         end
         set_flow(flow_t'(p % 4));
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) random_traffic();
      end
      wait_quiet();

      $display("covered %0d request words and %0d checked display words", words_sent,
               digits_checked);
      $display("over eight sign_flip settings, four flow mixes and one long output hold");
      if (errors == 0 && digits_due == 0) begin
         $display("[readout_seven_segment_display] OK");
      end else begin
         $display("[readout_seven_segment_display] ERROR");
      end
      $finish;
   end

endmodule
